FILE: design/mvm_pkg.sv
// Shared types and constants for the matrix vector multiply core.
`timescale 1ns / 1ps
`default_nettype none
package mvm_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W = 4;
    localparam int KIND_W = 2;
    localparam int SIZE_W = 5;

    localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

    localparam logic [KIND_W-1:0] KIND_MAT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VEC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MUL = 2'd2;

    typedef struct packed {
        logic valid;
        logic last;
    } t_tok;

endpackage
`default_nettype wire

FILE: design/mvm_cmd_if.sv
// Input channel carrying load and compute transactions.
`timescale 1ns / 1ps
`default_nettype none
interface mvm_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [mvm_pkg::KIND_W-1:0]         kind;
    logic [mvm_pkg::IDX_W-1:0]          row;
    logic [mvm_pkg::IDX_W-1:0]          col;
    logic signed [mvm_pkg::DATA_W-1:0]  value;

    modport source (output valid, output kind, output row, output col, output value,
                    input ready);
    modport sink (input valid, input kind, input row, input col, input value,
                  output ready);
endinterface
`default_nettype wire

FILE: design/mvm_res_if.sv
// Output channel carrying one result element per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface mvm_res_if;
    logic                               valid;
    logic                               ready;
    logic [mvm_pkg::IDX_W-1:0]          out_index;
    logic signed [mvm_pkg::DATA_W-1:0]  out_value;
    logic                               saturated;
    logic                               last;

    modport source (output valid, output out_index, output out_value, output saturated,
                    output last, input ready);
    modport sink (input valid, input out_index, input out_value, input saturated,
                  input last, output ready);
endinterface
`default_nettype wire

FILE: design/matrix_vector_multiply_core.sv
// Top level of the matrix vector multiply core: control, write steering and the cell chain.
// A load transaction leaves the core idle, so the core stays ready and loads can be taken back to back.
// A compute transaction passes through the three register stages in each of the MAX_DIM cells
// and the output register, then delivers one result per cycle while the result channel does not stall.
// After a compute acceptance the core takes no new transaction until its last row has left the cell chain.
// After reset the column memories are cleared at one row per cycle, and the core is not ready until all are clear.
`timescale 1ns / 1ps
`default_nettype none
module matrix_vector_multiply_core #(
    parameter int MAX_DIM   = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [mvm_pkg::SIZE_W-1:0]   i_cfg_data,
    mvm_cmd_if.sink                           i_cmd,
    mvm_res_if.source                         o_res
);
    localparam int AW    = $clog2(MAX_DIM);
    localparam int NW    = $clog2(MAX_DIM + 1);
    localparam int ACC_W = 2 * mvm_pkg::DATA_W + $clog2(MAX_DIM);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_ISSUE = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [AW-1:0]               r_row, n_row;
    logic [mvm_pkg::SIZE_W-1:0]  r_size;
    logic [NW-1:0]               dim_used;
    logic                        chain_en;
    logic                        accept;
    logic                        row_last;
    logic                        clearing;
    logic                        row_ok;
    logic [AW-1:0]               wr_addr;
    logic signed [mvm_pkg::DATA_W-1:0] wr_data;
    logic [MAX_DIM-1:0]          mem_we;
    logic [MAX_DIM-1:0]          vec_we;
    logic [MAX_DIM-1:0]          cell_valid;

    mvm_pkg::t_tok               chain_tok [MAX_DIM+1];
    logic [AW-1:0]               chain_row [MAX_DIM+1];
    logic signed [ACC_W-1:0]     chain_sum [MAX_DIM+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= mvm_pkg::SIZE_RST;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
        end
    end

    always_comb begin
        priority if (r_size == '0) begin
            dim_used = NW'(1);
        end else if (int'(r_size) > MAX_DIM) begin
            dim_used = NW'(MAX_DIM);
        end else begin
            dim_used = NW'(r_size);
        end
    end

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign row_last    = (int'(r_row) + 1 == int'(dim_used));
    assign clearing    = (r_state == ST_CLEAR);
    assign row_ok      = (int'(i_cmd.row) < MAX_DIM);
    assign wr_addr     = clearing ? r_row : AW'(i_cmd.row);
    assign wr_data     = clearing ? '0 : i_cmd.value;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        unique case (r_state)
            ST_CLEAR: begin
                if (int'(r_row) == MAX_DIM - 1) begin
                    n_state = ST_IDLE;
                    n_row   = '0;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept && i_cmd.kind == mvm_pkg::KIND_MUL) begin
                    n_state = ST_ISSUE;
                    n_row   = '0;
                end
            end
            ST_ISSUE: begin
                if (chain_en) begin
                    if (row_last) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (chain_en && chain_tok[MAX_DIM].valid && chain_tok[MAX_DIM].last) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    assign chain_tok[0].valid = (r_state == ST_ISSUE);
    assign chain_tok[0].last  = row_last;
    assign chain_row[0]       = r_row;
    assign chain_sum[0]       = '0;

    for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
        assign mem_we[j] = clearing || (accept && i_cmd.kind == mvm_pkg::KIND_MAT && row_ok
                                        && int'(i_cmd.col) == j);
        assign vec_we[j] = accept && i_cmd.kind == mvm_pkg::KIND_VEC && int'(i_cmd.col) == j;

        mvm_cell #(
            .MAX_DIM  (MAX_DIM),
            .CELL_IDX (j),
            .ACC_W    (ACC_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (chain_en),
            .i_dim       (dim_used),
            .i_tok       (chain_tok[j]),
            .i_row       (chain_row[j]),
            .i_sum       (chain_sum[j]),
            .i_mem_we    (mem_we[j]),
            .i_mem_addr  (wr_addr),
            .i_mem_data  (wr_data),
            .i_vec_we    (vec_we[j]),
            .i_vec_data  (i_cmd.value),
            .o_tok_valid (cell_valid[j]),
            .o_tok       (chain_tok[j+1]),
            .o_row       (chain_row[j+1]),
            .o_sum       (chain_sum[j+1])
        );
    end

    mvm_out_stage #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS),
        .ACC_W     (ACC_W)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (chain_tok[MAX_DIM]),
        .i_row   (chain_row[MAX_DIM]),
        .i_sum   (chain_sum[MAX_DIM]),
        .o_en    (chain_en),
        .o_res   (o_res)
    );

    // Tokens in the chain exist only while a compute transaction is in progress.
    a_chain_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_valid != '0) |-> (r_state == ST_ISSUE || r_state == ST_DRAIN))
        else $error("chain token outside a compute run");

    // The column memories are never written while the chain reads them.
    a_no_write_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE || r_state == ST_DRAIN) |-> (mem_we == '0 && vec_we == '0))
        else $error("store written during compute");

    // The issue counter stays below the active size.
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (int'(r_row) < int'(dim_used)))
        else $error("issued row beyond active size");

    // No result appears during the clearing pass.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_res.valid)
        else $error("result during clearing pass");
endmodule
`default_nettype wire

FILE: design/mvm_cell.sv
// One chain cell: a matrix column, a vector element and a multiply-accumulate stage.
`timescale 1ns / 1ps
`default_nettype none
module mvm_cell #(
    parameter int MAX_DIM  = 16,
    parameter int CELL_IDX = 0,
    parameter int ACC_W    = 68
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic [$clog2(MAX_DIM+1)-1:0]          i_dim,
    input  wire mvm_pkg::t_tok                         i_tok,
    input  wire logic [$clog2(MAX_DIM)-1:0]            i_row,
    input  wire logic signed [ACC_W-1:0]               i_sum,
    input  wire logic                                  i_mem_we,
    input  wire logic [$clog2(MAX_DIM)-1:0]            i_mem_addr,
    input  wire logic signed [mvm_pkg::DATA_W-1:0]     i_mem_data,
    input  wire logic                                  i_vec_we,
    input  wire logic signed [mvm_pkg::DATA_W-1:0]     i_vec_data,
    output logic                                       o_tok_valid,
    output mvm_pkg::t_tok                              o_tok,
    output logic [$clog2(MAX_DIM)-1:0]                 o_row,
    output logic signed [ACC_W-1:0]                    o_sum
);
    localparam int AW = $clog2(MAX_DIM);
    localparam int PW = 2 * mvm_pkg::DATA_W;

    logic signed [mvm_pkg::DATA_W-1:0] r_mem [MAX_DIM];
    logic signed [mvm_pkg::DATA_W-1:0] r_rd;
    logic signed [mvm_pkg::DATA_W-1:0] r_vec;
    logic signed [PW-1:0]              r_prod;

    mvm_pkg::t_tok           r_a_tok, r_b_tok, r_c_tok;
    logic [AW-1:0]           r_a_row, r_b_row, r_c_row;
    logic signed [ACC_W-1:0] r_a_sum, r_b_sum, r_c_sum;
    logic                    active;

    assign active = (CELL_IDX < int'(i_dim));

    always_ff @(posedge i_clk) begin
        if (i_mem_we) begin
            r_mem[i_mem_addr] <= i_mem_data;
        end
        if (i_en) begin
            r_rd <= r_mem[i_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec <= '0;
        end else if (i_vec_we) begin
            r_vec <= i_vec_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tok <= '0;
            r_b_tok <= '0;
            r_c_tok <= '0;
        end else if (i_en) begin
            r_a_tok <= i_tok;
            r_b_tok <= r_a_tok;
            r_c_tok <= r_b_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_row <= i_row;
            r_a_sum <= i_sum;
            r_b_row <= r_a_row;
            r_b_sum <= r_a_sum;
            if (active) begin
                r_prod <= r_rd * r_vec;
            end else begin
                r_prod <= '0;
            end
            r_c_row <= r_b_row;
            r_c_sum <= r_b_sum + ACC_W'(r_prod);
        end
    end

    assign o_tok       = r_c_tok;
    assign o_tok_valid = r_c_tok.valid;
    assign o_row       = r_c_row;
    assign o_sum       = r_c_sum;
endmodule
`default_nettype wire

FILE: design/mvm_out_stage.sv
// Fixed-point scaling, saturation and the output register of the result channel.
`timescale 1ns / 1ps
`default_nettype none
module mvm_out_stage #(
    parameter int MAX_DIM   = 16,
    parameter int FRAC_BITS = 16,
    parameter int ACC_W     = 68
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mvm_pkg::t_tok               i_tok,
    input  wire logic [$clog2(MAX_DIM)-1:0]  i_row,
    input  wire logic signed [ACC_W-1:0]     i_sum,
    output logic                             o_en,
    mvm_res_if.source                        o_res
);
    localparam int DW = mvm_pkg::DATA_W;

    logic signed [ACC_W-1:0]  shifted;
    logic                     fits;
    logic                     r_valid;
    logic [mvm_pkg::IDX_W-1:0] r_index;
    logic signed [DW-1:0]     r_value;
    logic                     r_sat;
    logic                     r_last;

    assign shifted = i_sum >>> FRAC_BITS;
    assign fits    = (&shifted[ACC_W-1:DW-1]) || !(|shifted[ACC_W-1:DW-1]);
    assign o_en    = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_tok.valid) begin
            r_index <= mvm_pkg::IDX_W'(i_row);
            r_sat   <= !fits;
            r_last  <= i_tok.last;
            if (fits) begin
                r_value <= shifted[DW-1:0];
            end else if (i_sum[ACC_W-1]) begin
                r_value <= {1'b1, {(DW-1){1'b0}}};
            end else begin
                r_value <= {1'b0, {(DW-1){1'b1}}};
            end
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.out_index = r_index;
    assign o_res.out_value = r_value;
    assign o_res.saturated = r_sat;
    assign o_res.last      = r_last;
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for the matrix vector multiply core, checked against a built-in product predictor.
`timescale 1ns / 1ps
module tb_top;

    localparam int MAX_DIM = 16;
    localparam int FRAC_BITS = 16;
    localparam int CLK_HALF = 5;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 32;
    localparam logic [mvm_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
    localparam logic signed [71:0] SUM_MAX = 72'sd2147483647;
    localparam logic signed [71:0] SUM_MIN = -72'sd2147483648;

    typedef struct {
        logic [mvm_pkg::KIND_W-1:0]        kind;
        logic [mvm_pkg::IDX_W-1:0]         row;
        logic [mvm_pkg::IDX_W-1:0]         col;
        logic signed [mvm_pkg::DATA_W-1:0] value;
    } t_cmd_item;

    typedef struct {
        logic [mvm_pkg::IDX_W-1:0]         index;
        logic signed [mvm_pkg::DATA_W-1:0] value;
        logic                              saturated;
        logic                              last;
    } t_dot_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [mvm_pkg::SIZE_W-1:0] i_cfg_data;

    mvm_cmd_if cmd_if ();
    mvm_res_if res_if ();

    matrix_vector_multiply_core #(
        .MAX_DIM  (MAX_DIM),
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_cmd     (cmd_if),
        .o_res     (res_if)
    );

    t_cmd_item                         cmd_pending_q[$];
    t_dot_result                       product_expect_q[$];
    logic signed [mvm_pkg::DATA_W-1:0] matrix_copy [MAX_DIM][MAX_DIM];
    logic signed [mvm_pkg::DATA_W-1:0] vector_copy [MAX_DIM];
    logic [mvm_pkg::SIZE_W-1:0]        size_copy = mvm_pkg::SIZE_RST;
    logic                              cmd_taken = 1'b0;
    logic                              res_hold = 1'b0;
    int                                send_idle_pct = 0;
    int                                recv_stall_pct = 0;
    int                                mismatch_count = 0;
    int                                idle_cycles = 0;
    int                                items_queued = 0;
    int                                cmds_pushed = 0;
    int                                cmds_accepted = 0;
    event                              start_res_hold;

    always #(CLK_HALF) i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void predict_products();
        logic signed [71:0]   acc;
        logic signed [63:0]   prod;
        logic signed [71:0]   shifted;
        t_dot_result          res;
        int                   n;
        int                   i;
        int                   j;
        n = size_copy;
        if (n == 0) n = 1;
        if (n > MAX_DIM) n = MAX_DIM;
        for (i = 0; i < n; i++) begin
            acc = '0;
            for (j = 0; j < n; j++) begin
                prod = matrix_copy[i][j] * vector_copy[j];
                acc = acc + prod;
            end
            shifted = acc >>> FRAC_BITS;
            res.index = mvm_pkg::IDX_W'(i);
            res.last = (i == n - 1);
            if (shifted > SUM_MAX) begin
                res.value = 32'sh7FFFFFFF;
                res.saturated = 1'b1;
            end else if (shifted < SUM_MIN) begin
                res.value = 32'sh80000000;
                res.saturated = 1'b1;
            end else begin
                res.value = shifted[mvm_pkg::DATA_W-1:0];
                res.saturated = 1'b0;
            end
            product_expect_q.push_back(res);
        end
    endfunction

    function automatic void apply_cmd(input t_cmd_item it);
        case (it.kind)
            mvm_pkg::KIND_MAT: matrix_copy[it.row][it.col] = it.value;
            mvm_pkg::KIND_VEC: vector_copy[it.col] = it.value;
            mvm_pkg::KIND_MUL: predict_products();
            default: ;
        endcase
    endfunction

    task automatic check_result();
        t_dot_result want;
        string       diffs;
        if (product_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result row %0d value %h",
                                      res_if.out_index, res_if.out_value));
        end else begin
            want = product_expect_q.pop_front();
            diffs = "";
            if (res_if.out_index !== want.index)
                diffs = {diffs, $sformatf(" index %0d want %0d", res_if.out_index, want.index)};
            if (res_if.out_value !== want.value)
                diffs = {diffs, $sformatf(" value %h want %h", res_if.out_value, want.value)};
            if (res_if.saturated !== want.saturated)
                diffs = {diffs, $sformatf(" sat %b want %b", res_if.saturated, want.saturated)};
            if (res_if.last !== want.last)
                diffs = {diffs, $sformatf(" last %b want %b", res_if.last, want.last)};
            if (diffs != "") report_mismatch({$sformatf("row %0d:", want.index), diffs});
        end
    endtask

    // Input driver: offers the next pending transaction once the current one is taken.
    always @(negedge i_clk) begin
        t_cmd_item next_item;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            if (cmd_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = cmd_pending_q.pop_front();
                cmd_if.valid <= 1'b1;
                cmd_if.kind <= next_item.kind;
                cmd_if.row <= next_item.row;
                cmd_if.col <= next_item.col;
                cmd_if.value <= next_item.value;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !res_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always begin
        @(start_res_hold);
        res_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        res_hold = 1'b0;
    end

    // Monitor: updates the predictor on accepted commands and checks accepted results.
    always @(posedge i_clk) begin
        t_cmd_item seen;
        int        r;
        int        c;
        if (!i_rst_n) begin
            size_copy = mvm_pkg::SIZE_RST;
            for (r = 0; r < MAX_DIM; r++) begin
                vector_copy[r] = '0;
                for (c = 0; c < MAX_DIM; c++) matrix_copy[r][c] = '0;
            end
            cmd_taken <= 1'b0;
            idle_cycles = 0;
        end else begin
            cmd_taken <= cmd_if.valid && cmd_if.ready;
            if (i_cfg_we) size_copy = i_cfg_data;
            if (cmd_if.valid && cmd_if.ready) begin
                seen.kind = cmd_if.kind;
                seen.row = cmd_if.row;
                seen.col = cmd_if.col;
                seen.value = cmd_if.value;
                apply_cmd(seen);
                cmds_accepted++;
            end
            if (res_if.valid && res_if.ready) check_result();
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic push_cmd(input logic [mvm_pkg::KIND_W-1:0] kind,
                            input logic [mvm_pkg::IDX_W-1:0] row,
                            input logic [mvm_pkg::IDX_W-1:0] col,
                            input logic signed [mvm_pkg::DATA_W-1:0] value);
        t_cmd_item it;
        it.kind = kind;
        it.row = row;
        it.col = col;
        it.value = value;
        cmd_pending_q.push_back(it);
        cmds_pushed++;
        if (kind != KIND_NONE) items_queued++;
    endtask

    function automatic logic [mvm_pkg::IDX_W-1:0] pick_index(input int n_eff);
        if ($urandom_range(99) < 85) return mvm_pkg::IDX_W'($urandom_range(n_eff - 1));
        return mvm_pkg::IDX_W'($urandom_range(MAX_DIM - 1));
    endfunction

    // Style 0 spans the full range, 1 stays small, 2 sits near the saturation boundary.
    function automatic logic signed [mvm_pkg::DATA_W-1:0] pick_value(input int style);
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(5))
                0: return 32'sh7FFFFFFF;
                1: return 32'sh80000000;
                2: return 32'sh00000000;
                3: return 32'sh00010000;
                4: return 32'shFFFFFFFF;
                default: return 32'shFFFF0000;
            endcase
        end
        if (style == 0) return $urandom;
        if (style == 1) return $signed(32'($urandom_range(0, 32'h7FFFF))) - 32'sh40000;
        return $signed(32'($urandom_range(0, 32'h3FFFFFF))) - 32'sh2000000;
    endfunction

    task automatic queue_sequence(input logic [mvm_pkg::SIZE_W-1:0] size_cfg);
        int n_eff;
        int n_loads;
        int pick;
        int style;
        int k;
        n_eff = (size_cfg == 0) ? 1 : (size_cfg > MAX_DIM) ? MAX_DIM : int'(size_cfg);
        style = $urandom_range(2);
        if ($urandom_range(9) == 0) begin
            n_loads = $urandom_range(1, 6);
            for (k = 0; k < n_loads; k++)
                push_cmd(mvm_pkg::KIND_W'($urandom_range(3)),
                         mvm_pkg::IDX_W'($urandom_range(15)),
                         mvm_pkg::IDX_W'($urandom_range(15)), $urandom);
        end else begin
            n_loads = $urandom_range(1, 2 * n_eff + 2);
            for (k = 0; k < n_loads; k++) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    push_cmd(KIND_NONE, mvm_pkg::IDX_W'($urandom_range(15)),
                             mvm_pkg::IDX_W'($urandom_range(15)), $urandom);
                end else if (pick < 60) begin
                    push_cmd(mvm_pkg::KIND_MAT, pick_index(n_eff), pick_index(n_eff),
                             pick_value(style));
                end else begin
                    push_cmd(mvm_pkg::KIND_VEC, mvm_pkg::IDX_W'($urandom_range(15)),
                             pick_index(n_eff), pick_value(style));
                end
            end
            push_cmd(mvm_pkg::KIND_MUL, mvm_pkg::IDX_W'($urandom_range(15)),
                     mvm_pkg::IDX_W'($urandom_range(15)), $urandom);
        end
    endtask

    task automatic drain_results();
        while (cmds_accepted != cmds_pushed || product_expect_q.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_size(input logic [mvm_pkg::SIZE_W-1:0] size_val);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= size_val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 78; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 78; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
    endtask

    initial begin
        logic [mvm_pkg::SIZE_W-1:0] phase_sizes [8];
        int                         phase;
        int                         target;
        int                         k;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.kind = mvm_pkg::KIND_MAT;
        cmd_if.row = '0;
        cmd_if.col = '0;
        cmd_if.value = '0;
        res_if.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: zero stores, saturation both ways, sign and rounding, ignored fields.
        push_cmd(mvm_pkg::KIND_MUL, 4'd15, 4'd15, -32'sd1);
        push_cmd(mvm_pkg::KIND_MAT, 4'd0, 4'd0, 32'sh7FFFFFFF);
        push_cmd(mvm_pkg::KIND_VEC, 4'd15, 4'd0, 32'sh7FFFFFFF);
        push_cmd(mvm_pkg::KIND_MAT, 4'd1, 4'd0, 32'sh80000000);
        push_cmd(mvm_pkg::KIND_MAT, 4'd15, 4'd15, 32'sh80000000);
        push_cmd(mvm_pkg::KIND_VEC, 4'd0, 4'd15, 32'sh80000000);
        push_cmd(mvm_pkg::KIND_MAT, 4'd2, 4'd1, 32'sh00010000);
        push_cmd(mvm_pkg::KIND_VEC, 4'd7, 4'd1, 32'shFFFF0000);
        push_cmd(mvm_pkg::KIND_MAT, 4'd3, 4'd2, 32'shFFFFFFFF);
        push_cmd(mvm_pkg::KIND_VEC, 4'd0, 4'd2, 32'sh00000001);
        push_cmd(mvm_pkg::KIND_MAT, 4'd4, 4'd3, 32'sh00018000);
        push_cmd(mvm_pkg::KIND_VEC, 4'd0, 4'd3, 32'shFFFE8000);
        push_cmd(KIND_NONE, 4'd0, 4'd0, 32'sh00000000);
        push_cmd(mvm_pkg::KIND_MUL, 4'd0, 4'd0, 32'sh00000000);
        drain_results();
        write_size(5'd0);
        push_cmd(mvm_pkg::KIND_MUL, 4'd0, 4'd0, 32'sh0);
        drain_results();
        write_size(5'd31);
        push_cmd(mvm_pkg::KIND_MUL, 4'd0, 4'd0, 32'sh0);
        drain_results();
        write_size(5'd1);
        push_cmd(mvm_pkg::KIND_MAT, 4'd0, 4'd5, 32'sh00020000);
        push_cmd(mvm_pkg::KIND_VEC, 4'd0, 4'd5, 32'sh00030000);
        push_cmd(mvm_pkg::KIND_MUL, 4'd0, 4'd0, 32'sh0);
        drain_results();
        write_size(5'd6);
        push_cmd(mvm_pkg::KIND_MUL, 4'd0, 4'd0, 32'sh0);
        drain_results();
        write_size(5'd17);
        push_cmd(mvm_pkg::KIND_MUL, 4'd0, 4'd0, 32'sh0);
        drain_results();

        phase_sizes[0] = 5'd16;
        phase_sizes[1] = 5'd1;
        phase_sizes[2] = 5'd0;
        phase_sizes[3] = 5'd31;
        phase_sizes[4] = 5'd8;
        phase_sizes[5] = mvm_pkg::SIZE_W'($urandom_range(2, 15));
        phase_sizes[6] = 5'd17;
        phase_sizes[7] = mvm_pkg::SIZE_W'($urandom_range(0, 31));
        for (phase = 0; phase < 8; phase++) begin
            write_size(phase_sizes[phase]);
            set_idling(phase % 4);
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target) queue_sequence(phase_sizes[phase]);
            drain_results();

            if (phase == 3) begin
                // Results are held off while the sender keeps offering, so the core backs up.
                write_size(5'd16);
                set_idling(0);
                -> start_res_hold;
                for (k = 0; k < 3; k++) queue_sequence(5'd16);
                push_cmd(mvm_pkg::KIND_MUL, 4'd0, 4'd0, 32'sh0);
                push_cmd(mvm_pkg::KIND_MUL, 4'd0, 4'd0, 32'sh0);
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: files.f
design/mvm_pkg.sv
design/mvm_cmd_if.sv
design/mvm_res_if.sv
design/mvm_cell.sv
design/mvm_out_stage.sv
design/matrix_vector_multiply_core.sv
tb/sv/tb_top.sv
